// File: sv/tbpf_pkg.sv
// ---------------------------------------------------------------------------
// tbpf_pkg
// Shared types and constants for the tile background pixel fetch block.
// ---------------------------------------------------------------------------
`default_nettype none

package tbpf_pkg;

  // Video memory geometry: bytes in two banks of even and odd addresses
  localparam int unsigned VRAM_BYTES = 8192;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int unsigned BANK_DEPTH = VRAM_BYTES / 2;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

  // Tile map bases, as offsets from the start of video memory
  localparam logic [VRAM_AW-1:0] MAP_LOW_OFS  = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_OFS = 13'h1C00;

  // Request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE  = 3'd5;

endpackage

`default_nettype wire

// File: sv/tbpf_if.sv
// ---------------------------------------------------------------------------
// tbpf channel interfaces
// Request channel (memory writes and pixel requests) and result channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbpf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [12:0] mem_offset;
  logic [7:0]  mem_byte;
  logic [7:0]  pixel_column;
  logic [7:0]  pixel_line;

  modport source (
    output valid, req_type, mem_offset, mem_byte, pixel_column, pixel_line,
    input  ready
  );
  modport sink (
    input  valid, req_type, mem_offset, mem_byte, pixel_column, pixel_line,
    output ready
  );
endinterface

interface tbpf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade;
  logic [7:0] out_column;
  logic [7:0] out_line;

  modport source (
    output valid, shade, out_column, out_line,
    input  ready
  );
  modport sink (
    input  valid, shade, out_column, out_line,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/tile_background_pixel_fetch.sv
// ---------------------------------------------------------------------------
// tile_background_pixel_fetch
// Background pixel fetch: 8 KiB video memory, tile map lookup, bit-plane
// fetch and palette mapping to a 2-bit shade.
// ---------------------------------------------------------------------------
//
//   port        dir   role
//   ----------  ----  ---------------------------------------------------
//   req_i       sink  memory byte writes and pixel requests
//   res_o       src   one shade per pixel request, column and line echoed
//   cfg_*_i     in    register writes (enable, data mode, map, scroll, pal)
//
// A write goes to its bank on acceptance; the input stays ready. A pixel
// runs through accept and tile map read, tile row read, shade into the
// output register; the two dependent reads share the banks' single port.
// The output register frees the sequencer; a stalled result holds it in
// its last step until the register drains. No clearing pass after reset:
// video memory contents are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_fetch
  import tbpf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tbpf_req_if.sink                   req_i,
  tbpf_res_if.source                 res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic       bg_enable_q, unsigned_q, high_map_q;
  logic [7:0] scroll_x_q, scroll_y_q, palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_enable_q <= 1'b0;
      unsigned_q  <= 1'b0;
      high_map_q  <= 1'b0;
      scroll_x_q  <= '0;
      scroll_y_q  <= '0;
      palette_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BG_ENABLE:  bg_enable_q <= cfg_data_i[0];
        CFG_UNSIGNED:   unsigned_q  <= cfg_data_i[0];
        CFG_HIGH_MAP:   high_map_q  <= cfg_data_i[0];
        CFG_SCROLL_X:   scroll_x_q  <= cfg_data_i;
        CFG_SCROLL_Y:   scroll_y_q  <= cfg_data_i;
        CFG_BG_PALETTE: palette_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake
  logic accept, acc_write, acc_pixel;
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign acc_write   = accept && (req_i.req_type == REQ_WRITE);
  assign acc_pixel   = accept && (req_i.req_type == REQ_PIXEL);

  // Scrolled coordinates and tile map address
  logic [7:0]         wx, wy;
  logic [VRAM_AW-1:0] map_base, map_addr;
  assign wx       = req_i.pixel_column + scroll_x_q;
  assign wy       = req_i.pixel_line + scroll_y_q;
  assign map_base = high_map_q ? MAP_HIGH_OFS : MAP_LOW_OFS;
  assign map_addr = map_base + {3'b000, wy[7:3], wx[7:3]};

  // Per-pixel context carried through the sequence
  logic       map_odd_q;
  logic [2:0] fine_x_q, row_q;
  logic [7:0] col_q, line_q;

  always_ff @(posedge clk_i) begin
    if (acc_pixel) begin
      map_odd_q <= map_addr[0];
      fine_x_q  <= wx[2:0];
      row_q     <= wy[2:0];
      col_q     <= req_i.pixel_column;
      line_q    <= req_i.pixel_line;
    end
  end

  // Video memory banks: even bytes hold plane 0, odd bytes plane 1
  logic [BANK_AW-1:0] bank_addr;
  logic [7:0]         even_rd, odd_rd;
  logic               even_we, odd_we;
  logic [7:0]         tile_rd, tile_q, tile;
  logic [BANK_AW-1:0] data_word;

  assign tile_rd = map_odd_q ? odd_rd : even_rd;

  // Tile number is kept while the result waits, so the row read repeats
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAP) begin
      tile_q <= tile_rd;
    end
  end

  assign tile = (state_q == ST_MAP) ? tile_rd : tile_q;

  // Signed mode puts tiles 0..127 at offset 0x1000 and 128..255 at 0x0800
  assign data_word = {(~unsigned_q) & ~tile[7], tile, row_q};

  assign even_we = acc_write && !req_i.mem_offset[0];
  assign odd_we  = acc_write &&  req_i.mem_offset[0];

  always_comb begin
    if (state_q inside {ST_MAP, ST_DATA}) begin
      bank_addr = data_word;
    end else if (acc_write) begin
      bank_addr = req_i.mem_offset[VRAM_AW-1:1];
    end else begin
      bank_addr = map_addr[VRAM_AW-1:1];
    end
  end

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .addr_i  (bank_addr),
    .wdata_i (req_i.mem_byte),
    .rdata_o (even_rd)
  );

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .addr_i  (bank_addr),
    .wdata_i (req_i.mem_byte),
    .rdata_o (odd_rd)
  );

  // Colour from the two planes, then palette lookup
  logic [2:0] bit_idx;
  logic [1:0] colour, shade;
  assign bit_idx = ~fine_x_q;
  assign colour  = {odd_rd[bit_idx], even_rd[bit_idx]};
  assign shade   = bg_enable_q ? palette_q[{colour, 1'b0} +: 2] : 2'd0;

  // Output register
  logic       res_valid_q;
  logic [1:0] shade_q;
  logic [7:0] out_col_q, out_line_q;
  logic       res_load;

  assign res_load = (state_q == ST_DATA) && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      shade_q    <= shade;
      out_col_q  <= col_q;
      out_line_q <= line_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.shade      = shade_q;
  assign res_o.out_column = out_col_q;
  assign res_o.out_line   = out_line_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc_pixel) state_d = ST_MAP;
      ST_MAP:  state_d = ST_DATA;
      ST_DATA: if (res_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/tbpf_ram.sv
// ---------------------------------------------------------------------------
// tbpf_ram
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tbpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: sv/tbpf_checker.sv
// ---------------------------------------------------------------------------
// tbpf_checker
// Port-level checks on the tile background pixel fetch block.
// ---------------------------------------------------------------------------
`default_nettype none

module tbpf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_shade,
  input wire logic [7:0] out_column,
  input wire logic [7:0] out_line
);

  logic in_txn;
  assign in_txn = in_valid && in_ready;

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_shade) &&
    $stable(out_column) && $stable(out_line))
    else $error("result changed while stalled");

  // A pixel transaction blocks further input on the next cycle
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && in_type |=> !in_ready)
    else $error("input accepted while pixel in flight");

  // A memory write leaves the input ready in the cycle after it
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && !in_type |=> in_ready)
    else $error("write held input off");

  // No result appears right after a pixel transaction
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && in_type |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .in_type    (req_i.req_type),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_shade  (res_o.shade),
  .out_column (res_o.out_column),
  .out_line   (res_o.out_line)
);

`default_nettype wire
